/* rtl/gfau_pkg.sv */
// shared constants and types for the binary field arithmetic unit
`default_nettype none

package gfau_pkg;

  // field size limits
  localparam int MAX_DEGREE = 32;
  localparam int DATA_W     = 32;
  localparam int MIN_DEGREE = 2;
  localparam int TOP_DEGREE = (MAX_DEGREE < DATA_W) ? MAX_DEGREE : DATA_W;

  // derived widths
  localparam int DEG_W   = 6;
  localparam int MODE_W  = 2;
  localparam int SHIFT_W = $clog2(DATA_W);
  localparam int PROD_W  = 2 * DATA_W - 1;
  localparam int HALF_W  = DATA_W / 2;

  // reduction pipeline: a fixed number of shift-and-xor steps per stage
  localparam int RED_STEPS  = 8;
  localparam int RED_STAGES = (DATA_W - 1 + RED_STEPS - 1) / RED_STEPS;

  // configuration register map
  localparam int CFG_IDX_W = 1;
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FIELD_DEGREE   = 1'b0,
    CFG_REDUCTION_POLY = 1'b1
  } cfg_idx_t;

  localparam logic [DEG_W-1:0]  DEGREE_RESET = DEG_W'(8);
  localparam logic [DATA_W-1:0] POLY_RESET   = DATA_W'(29);

  // operation codes
  typedef enum logic [MODE_W-1:0] {
    MODE_ADD = 2'd0,
    MODE_SUB = 2'd1,
    MODE_NEG = 2'd2,
    MODE_MUL = 2'd3
  } mode_t;

  // field settings as the datapath sees them
  typedef struct packed {
    logic [DATA_W-1:0]  mask;     // low m bits set
    logic [SHIFT_W-1:0] shift;    // DATA_W - m
    logic [DATA_W-1:0]  poly_al;  // low polynomial terms moved up by shift
  } cfg_view_t;

  // after operand masking and alignment
  typedef struct packed {
    logic              is_mul;
    logic [DATA_W-1:0] lin;
    logic [DATA_W-1:0] a_al;
    logic [DATA_W-1:0] b;
  } opnd_t;

  // after partial product formation
  typedef struct packed {
    logic              is_mul;
    logic [DATA_W-1:0] lin;
    logic [PROD_W-1:0] pp_lo;
    logic [PROD_W-1:0] pp_hi;
  } part_t;

  // inside the reduction pipeline
  typedef struct packed {
    logic              is_mul;
    logic [DATA_W-1:0] lin;
    logic [PROD_W-1:0] prod;
  } red_t;

endpackage

`default_nettype wire

/* rtl/gfau_in_if.sv */
// input channel interface: operation and two operands
`default_nettype none

interface gfau_in_if import gfau_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [MODE_W-1:0] mode;
  logic [DATA_W-1:0] operand_a;
  logic [DATA_W-1:0] operand_b;

  modport source (output valid, mode, operand_a, operand_b, input ready);
  modport sink   (input valid, mode, operand_a, operand_b, output ready);
endinterface

`default_nettype wire

/* rtl/gfau_out_if.sv */
// result channel interface: one field element
`default_nettype none

interface gfau_out_if import gfau_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] field_result;

  modport source (output valid, field_result, input ready);
  modport sink   (input valid, field_result, output ready);
endinterface

`default_nettype wire

/* rtl/gfau_cfg.sv */
// configuration registers and the field settings derived from them
`default_nettype none

module gfau_cfg import gfau_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DATA_W-1:0]    cfg_wdata,
  output cfg_view_t            view
);

  // clamp the degree and build mask, alignment shift and aligned polynomial
  function automatic cfg_view_t derive_view(input logic [DEG_W-1:0]  degree,
                                            input logic [DATA_W-1:0] poly);
    cfg_view_t        v;
    logic [DEG_W-1:0] m;
    logic [DEG_W-1:0] k;
    if (degree < DEG_W'(MIN_DEGREE)) begin
      m = DEG_W'(MIN_DEGREE);
    end else if (degree > DEG_W'(TOP_DEGREE)) begin
      m = DEG_W'(TOP_DEGREE);
    end else begin
      m = degree;
    end
    k         = DEG_W'(DATA_W) - m;
    v.shift   = k[SHIFT_W-1:0];
    v.mask    = {DATA_W{1'b1}} >> v.shift;
    v.poly_al = (poly & v.mask) << v.shift;
    return v;
  endfunction

  logic [DEG_W-1:0]  degree_r, degree_nxt;
  logic [DATA_W-1:0] poly_r,   poly_nxt;
  cfg_view_t         view_r,   view_nxt;

  // register writes
  always_comb begin
    degree_nxt = degree_r;
    poly_nxt   = poly_r;
    if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_FIELD_DEGREE:   degree_nxt = cfg_wdata[DEG_W-1:0];
        CFG_REDUCTION_POLY: poly_nxt   = cfg_wdata;
        default:            ;
      endcase
    end
    view_nxt = derive_view(degree_nxt, poly_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      degree_r <= DEGREE_RESET;
      poly_r   <= POLY_RESET;
      view_r   <= derive_view(DEGREE_RESET, POLY_RESET);
    end else begin
      degree_r <= degree_nxt;
      poly_r   <= poly_nxt;
      view_r   <= view_nxt;
    end
  end

  assign view = view_r;

  // the aligned polynomial never has terms below the alignment shift
  a_poly_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    (view_r.poly_al & ~(view_r.mask << view_r.shift)) == '0)
    else $error("aligned polynomial has terms outside the field");

endmodule

`default_nettype wire

/* rtl/gfau_front.sv */
// front stages: operand masking and alignment, then carry-less partial products
`default_nettype none

module gfau_front import gfau_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  cfg_view_t  view,
  gfau_in_if.sink    in_ch,
  output logic       dn_valid,
  output part_t      dn_data,
  input  logic       dn_ready
);

  // carry-less product of a with one half of b
  function automatic logic [PROD_W-1:0] clmul_half(input logic [DATA_W-1:0] a,
                                                   input logic [HALF_W-1:0] b_half);
    logic [PROD_W-1:0] acc;
    logic [PROD_W-1:0] a_ext;
    acc   = '0;
    a_ext = PROD_W'(a);
    for (int j = 0; j < HALF_W; j++) begin
      if (b_half[j]) begin
        acc = acc ^ (a_ext << j);
      end
    end
    return acc;
  endfunction

  logic  opnd_v_r;
  opnd_t opnd_r, opnd_nxt;
  logic  part_v_r;
  part_t part_r, part_nxt;
  logic  en_opnd, en_part;

  assign en_part     = !part_v_r || dn_ready;
  assign en_opnd     = !opnd_v_r || en_part;
  assign in_ch.ready = en_opnd;

  // stage one: mask operands, linear result, align a for the m-free reduction
  always_comb begin
    logic [DATA_W-1:0] a_m;
    logic [DATA_W-1:0] b_m;
    a_m             = in_ch.operand_a & view.mask;
    b_m             = in_ch.operand_b & view.mask;
    opnd_nxt.is_mul = (mode_t'(in_ch.mode) == MODE_MUL);
    opnd_nxt.lin    = (mode_t'(in_ch.mode) == MODE_NEG) ? a_m : (a_m ^ b_m);
    opnd_nxt.a_al   = a_m << view.shift;
    opnd_nxt.b      = b_m;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      opnd_v_r <= 1'b0;
    end else if (en_opnd) begin
      opnd_v_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en_opnd) begin
      opnd_r <= opnd_nxt;
    end
  end

  // stage two: two half-width partial products
  always_comb begin
    part_nxt.is_mul = opnd_r.is_mul;
    part_nxt.lin    = opnd_r.lin;
    part_nxt.pp_lo  = clmul_half(opnd_r.a_al, opnd_r.b[HALF_W-1:0]);
    part_nxt.pp_hi  = clmul_half(opnd_r.a_al, opnd_r.b[DATA_W-1:HALF_W]) << HALF_W;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      part_v_r <= 1'b0;
    end else if (en_part) begin
      part_v_r <= opnd_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en_part) begin
      part_r <= part_nxt;
    end
  end

  assign dn_valid = part_v_r;
  assign dn_data  = part_r;

endmodule

`default_nettype wire

/* rtl/gfau_reduce.sv */
// reduction pipeline: shift-and-xor steps against the aligned polynomial
`default_nettype none

module gfau_reduce import gfau_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [DATA_W-1:0] poly_al,
  input  logic              up_valid,
  input  part_t             up_data,
  output logic              up_ready,
  output logic              dn_valid,
  output red_t              dn_data,
  input  logic              dn_ready
);

  // clear product bits top down to DATA_W, at most RED_STEPS of them
  function automatic logic [PROD_W-1:0] reduce_steps(input logic [PROD_W-1:0] prod_in,
                                                     input logic [DATA_W-1:0] poly,
                                                     input int                top);
    logic [PROD_W-1:0] p;
    int                i;
    p = prod_in;
    for (int n = 0; n < RED_STEPS; n++) begin
      i = top - n;
      if (i >= DATA_W) begin
        if (p[i]) begin
          p[i -: DATA_W+1] = p[i -: DATA_W+1] ^ {1'b1, poly};
        end
      end
    end
    return p;
  endfunction

  logic stg_v_r [RED_STAGES];
  red_t stg_r   [RED_STAGES];
  red_t stg_nxt [RED_STAGES];
  red_t stg_in  [RED_STAGES];
  logic stg_vin [RED_STAGES];
  logic en      [RED_STAGES+1];

  assign en[RED_STAGES] = dn_ready;

  for (genvar s = 0; s < RED_STAGES; s++) begin : g_stage
    // stage input: the first one folds the two partial products together
    if (s == 0) begin : g_first
      assign stg_vin[s]       = up_valid;
      assign stg_in[s].is_mul = up_data.is_mul;
      assign stg_in[s].lin    = up_data.lin;
      assign stg_in[s].prod   = up_data.pp_lo ^ up_data.pp_hi;
    end else begin : g_next
      assign stg_vin[s] = stg_v_r[s-1];
      assign stg_in[s]  = stg_r[s-1];
    end

    assign en[s] = !stg_v_r[s] || en[s+1];

    always_comb begin
      stg_nxt[s]      = stg_in[s];
      stg_nxt[s].prod = reduce_steps(stg_in[s].prod, poly_al, PROD_W - 1 - s * RED_STEPS);
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        stg_v_r[s] <= 1'b0;
      end else if (en[s]) begin
        stg_v_r[s] <= stg_vin[s];
      end
    end

    always_ff @(posedge clk) begin
      if (en[s]) begin
        stg_r[s] <= stg_nxt[s];
      end
    end
  end

  assign up_ready = en[0];
  assign dn_valid = stg_v_r[RED_STAGES-1];
  assign dn_data  = stg_r[RED_STAGES-1];

  // every product bit at or above DATA_W is gone after the last stage
  a_fully_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    dn_valid |-> (dn_data.prod[PROD_W-1:DATA_W] == '0))
    else $error("product leaves reduction with high terms set");

endmodule

`default_nettype wire

/* rtl/binary_field_arith_unit_core.sv */
// top level of the GF(2^m) polynomial basis arithmetic unit
//
// Usage:
// - in_ch carries mode (add, subtract, negate A, multiply) and two packed
//   operands; a transfer happens when valid and ready are both high.
// - out_ch returns one field element per input item, in order, with the
//   bits from m upward cleared.
// - cfg_we/cfg_index/cfg_wdata write the field degree (index 0) and the low
//   reduction polynomial terms (index 1); write only while no item is in
//   flight. A write takes effect for items transferred from the next cycle.
// - Pipeline: an item passes two front stages, four reduction stages and the
//   output register before it can leave.
// - Throughput: one item per cycle while out_ch is not stalled. The reduction
//   of up to 31 product terms is spread over four stages of up to eight
//   shift-and-xor steps each, and this stage depth sets the latency.
// - Stalls: every stage holds its item while the next one is full and
//   stalled; bubbles are squeezed out, so in_ch.ready only falls once the
//   whole pipeline is full behind a stalled out_ch.
// - Reset (rst_n low at a clock edge) empties the pipeline and loads
//   degree 8 with polynomial x^8+x^4+x^3+x^2+1.
`default_nettype none

module binary_field_arith_unit_core import gfau_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DATA_W-1:0]    cfg_wdata,
  gfau_in_if.sink              in_ch,
  gfau_out_if.source           out_ch
);

  cfg_view_t         view;
  logic              part_valid;
  part_t             part_data;
  logic              part_ready;
  logic              red_valid;
  red_t              red_data;
  logic              red_ready;
  logic              out_v_r;
  logic [DATA_W-1:0] out_res_r, out_res_nxt;

  gfau_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .view      (view)
  );

  gfau_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .view     (view),
    .in_ch    (in_ch),
    .dn_valid (part_valid),
    .dn_data  (part_data),
    .dn_ready (part_ready)
  );

  gfau_reduce u_reduce (
    .clk      (clk),
    .rst_n    (rst_n),
    .poly_al  (view.poly_al),
    .up_valid (part_valid),
    .up_data  (part_data),
    .up_ready (part_ready),
    .dn_valid (red_valid),
    .dn_data  (red_data),
    .dn_ready (red_ready)
  );

  // output register: undo the alignment for products, pass linear results
  assign red_ready   = !out_v_r || out_ch.ready;
  assign out_res_nxt = red_data.is_mul ? (red_data.prod[DATA_W-1:0] >> view.shift)
                                       : red_data.lin;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (red_ready) begin
      out_v_r <= red_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (red_ready) begin
      out_res_r <= out_res_nxt;
    end
  end

  assign out_ch.valid        = out_v_r;
  assign out_ch.field_result = out_res_r;

  // results never carry terms at or above the field degree
  a_result_masked: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> ((out_ch.field_result & ~view.mask) == '0))
    else $error("result has terms above the field degree");

  // back-pressure on the input only comes from a stalled result transfer
  a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> (out_ch.valid && !out_ch.ready))
    else $error("input stalled while the result side is free");

endmodule

`default_nettype wire

/* dv/tb_binary_field_arith_unit_core.sv */
// self-checking testbench for the gf(2^m) arithmetic unit core
`timescale 1ns / 1ps

module tb_binary_field_arith_unit_core;
  import gfau_pkg::*;

  localparam int CLK_HALF       = 4;
  localparam int RESET_CYCLES   = 10;
  localparam int DRAIN_CYCLES   = 12;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_PHASES  = 11;
  localparam int PHASE_ITEMS    = 50;
  localparam int NUM_DIRECTED   = 24;

  // well-known low terms: x^8+x^4+x^3+x^2+1 and a degree 16 polynomial
  localparam logic [DATA_W-1:0] POLY_DEG8  = 32'h0000_001D;
  localparam logic [DATA_W-1:0] POLY_DEG16 = 32'h0000_03DD;

  localparam logic TYPED     = 1'b1;
  localparam logic PREDICTED = 1'b0;

  typedef struct packed {
    logic [DEG_W-1:0]  degree;
    logic [DATA_W-1:0] poly;
    mode_t             op;
    logic [DATA_W-1:0] a;
    logic [DATA_W-1:0] b;
    logic              typed;
    logic [DATA_W-1:0] result;
  } directed_row_t;

  // directed stimulus: field setting, operation, operands, known answer where obvious
  localparam directed_row_t DIRECTED_ROWS [NUM_DIRECTED] = '{
    '{6'd8,  32'd29,        MODE_ADD, 32'h0000_00FF, 32'h0000_000F, TYPED,     32'h0000_00F0},
    '{6'd8,  32'd29,        MODE_SUB, 32'h0000_00A5, 32'h0000_005A, TYPED,     32'h0000_00FF},
    '{6'd8,  32'd29,        MODE_NEG, 32'hFFFF_FFFF, 32'h1234_5678, TYPED,     32'h0000_00FF},
    '{6'd8,  32'd29,        MODE_MUL, 32'h0000_0000, 32'h0000_00FF, TYPED,     32'h0000_0000},
    '{6'd8,  32'd29,        MODE_MUL, 32'h0000_0001, 32'hFFFF_FFFF, TYPED,     32'h0000_00FF},
    '{6'd8,  32'd29,        MODE_MUL, 32'h0000_0080, 32'h0000_0002, TYPED,     32'h0000_001D},
    '{6'd8,  32'd29,        MODE_MUL, 32'h0000_00FF, 32'h0000_00FF, PREDICTED, 32'h0},
    '{6'd8,  32'd29,        MODE_ADD, 32'hFFFF_FF00, 32'h0000_FF00, TYPED,     32'h0000_0000},
    '{6'd0,  32'hFFFF_FFFF, MODE_ADD, 32'hFFFF_FFFF, 32'h0000_0000, TYPED,     32'h0000_0003},
    '{6'd0,  32'hFFFF_FFFF, MODE_MUL, 32'h0000_0002, 32'h0000_0002, TYPED,     32'h0000_0003},
    '{6'd0,  32'hFFFF_FFFF, MODE_MUL, 32'h0000_0003, 32'h0000_0003, PREDICTED, 32'h0},
    '{6'd63, 32'h0000_008D, MODE_NEG, 32'hFFFF_FFFF, 32'h0000_0000, TYPED,     32'hFFFF_FFFF},
    '{6'd63, 32'h0000_008D, MODE_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, TYPED,     32'h0000_0000},
    '{6'd63, 32'h0000_008D, MODE_MUL, 32'h8000_0000, 32'h0000_0002, TYPED,     32'h0000_008D},
    '{6'd63, 32'h0000_008D, MODE_MUL, 32'hFFFF_FFFF, 32'hFFFF_FFFF, PREDICTED, 32'h0},
    '{6'd32, 32'h0000_0000, MODE_MUL, 32'h8000_0000, 32'h8000_0000, TYPED,     32'h0000_0000},
    '{6'd32, 32'h0000_0000, MODE_MUL, 32'h1234_5678, 32'h9ABC_DEF0, PREDICTED, 32'h0},
    '{6'd3,  32'hFFFF_FFF8, MODE_MUL, 32'h0000_0004, 32'h0000_0002, TYPED,     32'h0000_0000},
    '{6'd3,  32'hFFFF_FFF8, MODE_MUL, 32'h0000_0007, 32'h0000_0007, PREDICTED, 32'h0},
    '{6'd33, 32'h0000_001D, MODE_SUB, 32'hDEAD_BEEF, 32'h0123_4567, PREDICTED, 32'h0},
    '{6'd16, 32'h0000_002B, MODE_MUL, 32'h0000_8000, 32'h0000_0002, TYPED,     32'h0000_002B},
    '{6'd1,  32'h0000_0001, MODE_MUL, 32'h0000_0003, 32'h0000_0003, PREDICTED, 32'h0},
    '{6'd16, POLY_DEG16,    MODE_MUL, 32'h0000_FFFF, 32'h0000_FFFF, PREDICTED, 32'h0},
    '{6'd2,  32'h0000_0003, MODE_NEG, 32'h0000_0003, 32'hFFFF_FFFF, TYPED,     32'h0000_0003}
  };

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [DATA_W-1:0] cfg_wdata;

  gfau_in_if  in_if ();
  gfau_out_if out_if ();

  binary_field_arith_unit_core u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_if),
    .out_ch    (out_if)
  );

  // field results still owed by the block, oldest first
  logic [DATA_W-1:0] pending_results [$];

  // copy of the field settings as last written
  logic [DEG_W-1:0]  cur_degree = DEGREE_RESET;
  logic [DATA_W-1:0] cur_poly   = POLY_RESET;

  int error_count     = 0;
  int results_checked = 0;
  int settings_used   = 1;
  int idle_cycles     = 0;

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  // field operation on packed elements, degree clamped to the supported range
  function automatic logic [DATA_W-1:0] gf_compute(mode_t op, logic [DATA_W-1:0] a,
                                                   logic [DATA_W-1:0] b,
                                                   logic [DEG_W-1:0] degree,
                                                   logic [DATA_W-1:0] poly);
    int m;
    int i;
    logic [63:0] mask;
    logic [63:0] am;
    logic [63:0] bm;
    logic [63:0] acc;
    logic [63:0] full;
    m = int'(degree);
    if (m < MIN_DEGREE) m = MIN_DEGREE;
    if (m > TOP_DEGREE) m = TOP_DEGREE;
    mask = (64'd1 << m) - 64'd1;
    am   = {32'd0, a} & mask;
    bm   = {32'd0, b} & mask;
    acc  = 64'd0;
    case (op)
      MODE_ADD, MODE_SUB: acc = am ^ bm;
      MODE_NEG: acc = am;
      default: begin
        // carry-less product, then shift-and-xor reduction from the top term down
        for (i = 0; i < m; i++)
          if (bm[i]) acc ^= am << i;
        full = ({32'd0, poly} & mask) | (64'd1 << m);
        for (i = 2 * m - 2; i >= m; i--)
          if (acc[i]) acc ^= full << (i - m);
      end
    endcase
    return acc[DATA_W-1:0] & mask[DATA_W-1:0];
  endfunction

  // idle length: mostly none, often short, now and then long
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [DATA_W-1:0] rand_operand();
    int unsigned r;
    r = $urandom_range(0, 9);
    case (r)
      0: return '0;
      1: return '1;
      2: return DATA_W'(1) << $urandom_range(0, DATA_W - 1);
      3: return $urandom & ((DATA_W'(1) << $urandom_range(1, DATA_W - 1)) - DATA_W'(1));
      default: return $urandom;
    endcase
  endfunction

  // one input transfer; the expected field result is queued when it is taken
  task automatic send_op(mode_t op, logic [DATA_W-1:0] a, logic [DATA_W-1:0] b,
                         logic [DATA_W-1:0] result);
    in_if.valid     <= 1'b1;
    in_if.mode      <= op;
    in_if.operand_a <= a;
    in_if.operand_b <= b;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    pending_results.push_back(result);
  endtask

  // let the pipeline run dry before touching the field settings
  task automatic quiesce();
    in_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // write degree then polynomial on consecutive edges, enable held high across both
  task automatic program_field(logic [DATA_W-1:0] degree_word, logic [DATA_W-1:0] poly);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_FIELD_DEGREE;
    cfg_wdata <= degree_word;
    @(posedge clk);
    cfg_index <= CFG_REDUCTION_POLY;
    cfg_wdata <= poly;
    @(posedge clk);
    cfg_we     <= 1'b0;
    cur_degree = degree_word[DEG_W-1:0];
    cur_poly   = poly;
    settings_used++;
  endtask

  // result side backpressure: runs of ready with stalls between
  initial begin : result_ready
    int unsigned hold;
    int unsigned stall;
    out_if.ready <= 1'b0;
    @(posedge clk);
    forever begin
      hold = ($urandom_range(0, 99) < 20) ? $urandom_range(40, 150) : $urandom_range(1, 8);
      out_if.ready <= 1'b1;
      repeat (hold) @(posedge clk);
      stall = ($urandom_range(0, 99) < 90) ? $urandom_range(1, 3) : $urandom_range(8, 40);
      out_if.ready <= 1'b0;
      repeat (stall) @(posedge clk);
    end
  end

  // result checker against the oldest outstanding expectation
  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected field_result, expected none, actual %h",
                 $time, out_if.field_result);
        error_count++;
      end else begin
        if (out_if.field_result !== pending_results[0]) begin
          $display("%0t: field_result mismatch, expected %h, actual %h",
                   $time, pending_results[0], out_if.field_result);
          error_count++;
        end
        void'(pending_results.pop_front());
        results_checked++;
      end
    end
  end

  // watchdog on cycles with no transfer of any kind
  initial begin : watchdog
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) || cfg_we)
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("%0t: watchdog expired with %0d results outstanding",
             $time, pending_results.size());
    $display("Regression FAIL");
    $finish;
  end

  initial begin : stimulus
    directed_row_t row;
    mode_t op;
    logic [DATA_W-1:0] a;
    logic [DATA_W-1:0] b;
    logic [DATA_W-1:0] poly;
    logic [DEG_W-1:0] degree;
    int unsigned pick;
    int unsigned gap;
    bit burst;

    rst_n           <= 1'b0;
    cfg_we          <= 1'b0;
    cfg_index       <= CFG_FIELD_DEGREE;
    cfg_wdata       <= '0;
    in_if.valid     <= 1'b0;
    in_if.mode      <= MODE_ADD;
    in_if.operand_a <= '0;
    in_if.operand_b <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // directed rows, first ones on the reset field settings
    for (int i = 0; i < NUM_DIRECTED; i++) begin
      row = DIRECTED_ROWS[i];
      if (row.degree != cur_degree || row.poly != cur_poly) begin
        quiesce();
        program_field({{(DATA_W - DEG_W){1'b0}}, row.degree}, row.poly);
      end
      send_op(row.op, row.a, row.b,
              row.typed ? row.result
                        : gf_compute(row.op, row.a, row.b, cur_degree, cur_poly));
    end

    // random phases, each on a fresh field setting
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      pick = $urandom_range(0, 99);
      poly = $urandom;
      if (pick < 10) begin
        // out of range degree, clamped by the block
        degree = ($urandom_range(0, 1) == 0) ? DEG_W'($urandom_range(0, 1))
                                              : DEG_W'($urandom_range(33, 63));
      end else if (pick < 25) begin
        degree = ($urandom_range(0, 1) == 0) ? DEG_W'(MIN_DEGREE) : DEG_W'(TOP_DEGREE);
        if ($urandom_range(0, 2) == 0) poly = ($urandom_range(0, 1) == 0) ? '0 : '1;
      end else if (pick < 40) begin
        // standard polynomials, sometimes with junk above the degree
        degree = ($urandom_range(0, 1) == 0) ? DEG_W'(8) : DEG_W'(16);
        poly   = (degree == DEG_W'(8)) ? POLY_DEG8 : POLY_DEG16;
        if ($urandom_range(0, 1) == 0) poly |= $urandom << (degree == DEG_W'(8) ? 8 : 16);
      end else begin
        degree = DEG_W'($urandom_range(MIN_DEGREE, TOP_DEGREE));
      end
      quiesce();
      // upper bits of the degree word are not part of the register
      program_field({DATA_W'($urandom) & ~DATA_W'({DEG_W{1'b1}})} | DATA_W'(degree), poly);

      burst = ($urandom_range(0, 3) == 0);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        op = ($urandom_range(0, 1) == 0) ? MODE_MUL : mode_t'($urandom_range(0, 3));
        a  = rand_operand();
        b  = rand_operand();
        send_op(op, a, b, gf_compute(op, a, b, cur_degree, cur_poly));
        gap = burst ? 0 : idle_len();
        if (gap != 0) begin
          in_if.valid     <= 1'b0;
          in_if.operand_a <= $urandom;
          repeat (gap) @(posedge clk);
        end
      end
    end

    // drain, then give stray results a chance to show up
    in_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("checked %0d field results over %0d field settings", results_checked,
             settings_used);
    $display("operations add, subtract, negate and multiply, %0d mismatches", error_count);
    if (error_count == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule

/* sim.f */
rtl/gfau_pkg.sv
rtl/gfau_in_if.sv
rtl/gfau_out_if.sv
rtl/gfau_cfg.sv
rtl/gfau_front.sv
rtl/gfau_reduce.sv
rtl/binary_field_arith_unit_core.sv
dv/tb_binary_field_arith_unit_core.sv
